>>> rtl/hnps_pkg.sv
// ---------------------------------------------------------------------------
// hnps_pkg
// Shared types and constants for the held-note priority stack.
// ---------------------------------------------------------------------------
package hnps_pkg;

   localparam logic [1:0]  MODE_QUERY   = 2'd0;
   localparam logic [1:0]  MODE_PRESS   = 2'd1;
   localparam logic [1:0]  MODE_RELEASE = 2'd2;

   localparam logic [7:0]  COUNT_MAX = 8'd255;
   localparam logic [11:0] TOTAL_MAX = 12'hFFF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic search;
      logic update;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

>>> rtl/hnps_ctrl.sv
// ---------------------------------------------------------------------------
// hnps_ctrl
// Sequencer for one request: capture, search, update, then result load.
// ---------------------------------------------------------------------------
module hnps_ctrl import hnps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/hnps_datapath.sv
// ---------------------------------------------------------------------------
// hnps_datapath
// Note stack registers with parallel match, push, count update and
// shift-down removal, plus the result register.
// ---------------------------------------------------------------------------
module hnps_datapath import hnps_pkg::*; #(
   parameter int STACK_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [1:0]  req_mode,
   input  logic [6:0]  req_note,
   input  logic [3:0]  req_slot_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_changed,
   output logic        rsp_full_flag,
   output logic [6:0]  rsp_top_note,
   output logic [4:0]  rsp_distinct_held,
   output logic [11:0] rsp_total_holds,
   output logic        rsp_note_is_held,
   output logic [6:0]  rsp_note_at_slot
);

   localparam int POS_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W      = $clog2(STACK_DEPTH + 1);
   localparam int SUM_W      = $clog2(STACK_DEPTH * 255 + 1);
   localparam int SUM_EXT_W  = (SUM_W > 12) ? SUM_W : 12;
   localparam int CNT_EXT_W  = (CNT_W > 5) ? CNT_W : 5;
   localparam int READ_SLOTS = (STACK_DEPTH < 16) ? STACK_DEPTH : 16;

   logic [6:0]       slot_ff [STACK_DEPTH];
   logic [6:0]       slot_in [STACK_DEPTH];
   logic [7:0]       hold_ff [STACK_DEPTH];
   logic [7:0]       hold_in [STACK_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_ff, sum_in;

   logic [1:0]       mode_ff;
   logic [6:0]       note_ff;
   logic [3:0]       idx_ff;

   logic             found_ff, found_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       hit_hold_ff, hit_hold_in;
   logic             changed_ff, changed_in;
   logic             full_ff, full_in;

   logic             rsp_valid_ff;
   logic             rsp_changed_ff;
   logic             rsp_full_ff;
   logic [6:0]       rsp_top_ff;
   logic [4:0]       rsp_distinct_ff;
   logic [11:0]      rsp_total_ff;
   logic             rsp_held_ff;
   logic [6:0]       rsp_slot_ff;

   logic             stack_full;
   logic             do_push;
   logic             do_inc;
   logic             do_release;
   logic             do_remove;
   logic [CNT_W-1:0] top_idx;
   logic [6:0]       top_note;
   logic             held_now;
   logic [6:0]       slot_note;
   logic [SUM_EXT_W-1:0] sum_ext;
   logic [CNT_EXT_W-1:0] count_ext;
   logic [11:0]      total_sat;

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         note_ff <= req_note;
         idx_ff  <= req_slot_index;
      end
   end

   // parallel search over live entries
   always_comb begin
      found_in    = 1'b0;
      pos_in      = '0;
      hit_hold_in = '0;
      for (int i = 0; i < STACK_DEPTH; i++) begin
         if (CNT_W'(i) < count_ff && slot_ff[i] == note_ff) begin
            found_in    = 1'b1;
            pos_in      = pos_in | POS_W'(i);
            hit_hold_in = hit_hold_in | hold_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search) begin
         found_ff    <= found_in;
         pos_ff      <= pos_in;
         hit_hold_ff <= hit_hold_in;
      end
   end

   // update decisions
   assign stack_full = (count_ff == CNT_W'(STACK_DEPTH));
   assign do_push    = cmd.update && mode_ff == MODE_PRESS && !found_ff && !stack_full;
   assign do_inc     = cmd.update && mode_ff == MODE_PRESS && found_ff &&
                       hit_hold_ff != COUNT_MAX;
   assign do_release = cmd.update && mode_ff == MODE_RELEASE && found_ff;
   assign do_remove  = do_release && hit_hold_ff <= 8'd1;

   always_comb begin
      changed_in = do_push || do_release;
      full_in    = mode_ff == MODE_PRESS && !found_ff && stack_full;
      count_in   = count_ff;
      sum_in     = sum_ff;
      if (do_push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_remove) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (do_push || do_inc) begin
         sum_in = sum_ff + SUM_W'(1);
      end else if (do_release) begin
         sum_in = sum_ff - SUM_W'(1);
      end
   end

   always_comb begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
         slot_in[i] = slot_ff[i];
         hold_in[i] = hold_ff[i];
      end
      // shift down over the removed entry
      for (int i = 0; i < STACK_DEPTH - 1; i++) begin
         if (do_remove && POS_W'(i) >= pos_ff) begin
            slot_in[i] = slot_ff[i + 1];
            hold_in[i] = hold_ff[i + 1];
         end
      end
      for (int i = 0; i < STACK_DEPTH; i++) begin
         if (do_push && CNT_W'(i) == count_ff) begin
            slot_in[i] = note_ff;
            hold_in[i] = 8'd1;
         end
         if (do_inc && POS_W'(i) == pos_ff) begin
            hold_in[i] = hold_ff[i] + 8'd1;
         end
         if (do_release && !do_remove && POS_W'(i) == pos_ff) begin
            hold_in[i] = hold_ff[i] - 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
         hold_ff[i] <= hold_in[i];
      end
      if (cmd.update) begin
         changed_ff <= changed_in;
         full_ff    <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   // result fields from the updated stack
   assign top_idx = count_ff - CNT_W'(1);
   assign top_note = (count_ff != '0) ? slot_ff[top_idx[POS_W-1:0]] : 7'd0;

   always_comb begin
      held_now = 1'b0;
      for (int i = 0; i < STACK_DEPTH; i++) begin
         if (CNT_W'(i) < count_ff && slot_ff[i] == note_ff) begin
            held_now = 1'b1;
         end
      end
   end

   always_comb begin
      slot_note = 7'd0;
      for (int i = 0; i < READ_SLOTS; i++) begin
         if (idx_ff == 4'(i) && CNT_W'(i) < count_ff) begin
            slot_note = slot_ff[i];
         end
      end
   end

   assign sum_ext   = SUM_EXT_W'(sum_ff);
   assign count_ext = CNT_EXT_W'(count_ff);
   assign total_sat = (sum_ext > SUM_EXT_W'(TOTAL_MAX)) ? TOTAL_MAX : sum_ext[11:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_changed_ff  <= changed_ff;
         rsp_full_ff     <= full_ff;
         rsp_top_ff      <= top_note;
         rsp_distinct_ff <= count_ext[4:0];
         rsp_total_ff    <= total_sat;
         rsp_held_ff     <= held_now;
         rsp_slot_ff     <= slot_note;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_changed       = rsp_changed_ff;
   assign rsp_full_flag     = rsp_full_ff;
   assign rsp_top_note      = rsp_top_ff;
   assign rsp_distinct_held = rsp_distinct_ff;
   assign rsp_total_holds   = rsp_total_ff;
   assign rsp_note_is_held  = rsp_held_ff;
   assign rsp_note_at_slot  = rsp_slot_ff;

endmodule

>>> rtl/held_note_priority_stack_core.sv
// ---------------------------------------------------------------------------
// held_note_priority_stack_core
// Last-note priority stack of held notes with per-note hold counts.
// ---------------------------------------------------------------------------
// Each request passes through capture, the parallel match over all stack
// entries, push, count or shift down, and building the response from the
// updated stack. The response register is loaded in the last step, which
// waits for as long as an earlier response is still stalled in the output
// register. The sequencer handles one request at a time. The next request
// can be accepted at the edge after the response register is loaded, even
// while that response is still stalled. The stack needs no clearing after
// reset.
module held_note_priority_stack_core import hnps_pkg::*; #(
   parameter int STACK_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [6:0]  req_note,
   input  logic [3:0]  req_slot_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_changed,
   output logic        rsp_full_flag,
   output logic [6:0]  rsp_top_note,
   output logic [4:0]  rsp_distinct_held,
   output logic [11:0] rsp_total_holds,
   output logic        rsp_note_is_held,
   output logic [6:0]  rsp_note_at_slot
);

   cmd_type    cmd;
   status_type status;

   hnps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   hnps_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_mode          (req_mode),
      .req_note          (req_note),
      .req_slot_index    (req_slot_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_changed       (rsp_changed),
      .rsp_full_flag     (rsp_full_flag),
      .rsp_top_note      (rsp_top_note),
      .rsp_distinct_held (rsp_distinct_held),
      .rsp_total_holds   (rsp_total_holds),
      .rsp_note_is_held  (rsp_note_is_held),
      .rsp_note_at_slot  (rsp_note_at_slot)
   );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the held-note priority stack. Key events are sent
// through named tests (basic events, full stack, random play, count
// saturation) while both channels idle at random. A behavioral copy of the
// stack predicts each response, and every response is compared field by
// field with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_top;
   import hnps_pkg::*;

   localparam int          DEPTH       = 16;
   localparam int          CYCLE_LIMIT = 200000;
   localparam logic [1:0]  MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic [6:0] note;
      logic [3:0] slot_index;
   } key_event_type;

   typedef struct packed {
      logic        changed;
      logic        full_flag;
      logic [6:0]  top_note;
      logic [4:0]  distinct_held;
      logic [11:0] total_holds;
      logic        note_is_held;
      logic [6:0]  note_at_slot;
   } stack_view_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_mode;
   logic [6:0]  req_note;
   logic [3:0]  req_slot_index;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_changed;
   logic        rsp_full_flag;
   logic [6:0]  rsp_top_note;
   logic [4:0]  rsp_distinct_held;
   logic [11:0] rsp_total_holds;
   logic        rsp_note_is_held;
   logic [6:0]  rsp_note_at_slot;

   // behavioral stack
   logic [6:0]  held_notes  [DEPTH];
   logic [7:0]  held_counts [DEPTH];
   int unsigned held_entries;
   stack_view_type view_queue [$];

   bit          no_gaps;
   int unsigned error_count;
   int unsigned cycle_count;
   int unsigned press_count;
   int unsigned release_count;
   int unsigned query_count;
   int unsigned full_hits;
   int unsigned saturated_hits;

   held_note_priority_stack_core #(.STACK_DEPTH(DEPTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_note          (req_note),
      .req_slot_index    (req_slot_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_changed       (rsp_changed),
      .rsp_full_flag     (rsp_full_flag),
      .rsp_top_note      (rsp_top_note),
      .rsp_distinct_held (rsp_distinct_held),
      .rsp_total_holds   (rsp_total_holds),
      .rsp_note_is_held  (rsp_note_is_held),
      .rsp_note_at_slot  (rsp_note_at_slot)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int find_held(logic [6:0] n);
      for (int i = 0; i < int'(held_entries); i++) begin
         if (held_notes[i] == n) return i;
      end
      return -1;
   endfunction

   function automatic stack_view_type apply_key_event(key_event_type ev);
      stack_view_type v;
      int          pos;
      int unsigned sum;
      v   = '0;
      pos = find_held(ev.note);
      case (ev.mode)
         MODE_PRESS: begin
            press_count++;
            if (pos >= 0) begin
               if (held_counts[pos] < COUNT_MAX) held_counts[pos]++;
               else saturated_hits++;
            end else if (held_entries >= DEPTH) begin
               v.full_flag = 1'b1;
               full_hits++;
            end else begin
               held_notes[held_entries]  = ev.note;
               held_counts[held_entries] = 8'd1;
               held_entries++;
               v.changed = 1'b1;
            end
         end
         MODE_RELEASE: begin
            release_count++;
            if (pos >= 0) begin
               v.changed = 1'b1;
               if (held_counts[pos] > 0) held_counts[pos]--;
               if (held_counts[pos] == 0) begin
                  for (int j = pos; j + 1 < int'(held_entries); j++) begin
                     held_notes[j]  = held_notes[j + 1];
                     held_counts[j] = held_counts[j + 1];
                  end
                  held_entries--;
               end
            end
         end
         default: query_count++;
      endcase
      sum = 0;
      for (int i = 0; i < int'(held_entries); i++) sum += held_counts[i];
      v.total_holds   = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[11:0];
      v.top_note      = (held_entries > 0) ? held_notes[held_entries - 1] : 7'd0;
      v.distinct_held = held_entries[4:0];
      v.note_is_held  = (find_held(ev.note) >= 0);
      v.note_at_slot  = (ev.slot_index < held_entries) ? held_notes[ev.slot_index] : 7'd0;
      return v;
   endfunction

   task automatic send_key_event(input logic [1:0] mode, input logic [6:0] note,
                                 input logic [3:0] slot);
      key_event_type ev;
      ev = '{mode, note, slot};
      while (!no_gaps && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_note       <= note;
      req_slot_index <= slot;
      do @(posedge clock); while (req_stall);
      view_queue.push_back(apply_key_event(ev));
   endtask

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : check_responses
      stack_view_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (view_queue.size() == 0) begin
            $display("%0t: response with no request pending", $time);
            error_count++;
         end else begin
            want = view_queue.pop_front();
            check_field("changed",       want.changed,       rsp_changed);
            check_field("full_flag",     want.full_flag,     rsp_full_flag);
            check_field("top_note",      want.top_note,      rsp_top_note);
            check_field("distinct_held", want.distinct_held, rsp_distinct_held);
            check_field("total_holds",   want.total_holds,   rsp_total_holds);
            check_field("note_is_held",  want.note_is_held,  rsp_note_is_held);
            check_field("note_at_slot",  want.note_at_slot,  rsp_note_at_slot);
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !no_gaps && ($urandom_range(99) < 26);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d responses outstanding", $time, view_queue.size());
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic test_basic_events();
      send_key_event(MODE_QUERY,   7'd127, 4'd15);
      send_key_event(MODE_RELEASE, 7'd64,  4'd0);
      send_key_event(MODE_PRESS,   7'd0,   4'd0);
      send_key_event(MODE_PRESS,   7'd127, 4'd1);
      send_key_event(MODE_PRESS,   7'd0,   4'd15);
      send_key_event(MODE_UNUSED,  7'd127, 4'd1);
      send_key_event(MODE_RELEASE, 7'd0,   4'd0);
      send_key_event(MODE_RELEASE, 7'd0,   4'd0);
      send_key_event(MODE_RELEASE, 7'd127, 4'd0);
   endtask

   task automatic test_full_stack();
      for (int i = 0; i < DEPTH; i++) send_key_event(MODE_PRESS, 7'(127 - i * 5), 4'(i));
      send_key_event(MODE_PRESS,   7'd1,   4'd15);
      send_key_event(MODE_PRESS,   7'd127, 4'd0);
      send_key_event(MODE_RELEASE, 7'd102, 4'd15);
      send_key_event(MODE_QUERY,   7'd102, 4'd14);
   endtask

   task automatic test_random_play(input int unsigned n_items);
      logic [6:0]  pool [24];
      int unsigned r;
      int unsigned press_pct;
      logic [6:0]  pick;
      for (int i = 0; i < 24; i++) pool[i] = 7'($urandom_range(127));
      pool[0] = 7'd0;
      pool[1] = 7'd127;
      for (int unsigned k = 0; k < n_items; k++) begin
         no_gaps   = (k >= n_items * 2 / 5) && (k < n_items * 3 / 5);
         press_pct = ((k / 60) % 2 == 0) ? 55 : 30;
         pick      = pool[$urandom_range(23)];
         r         = $urandom_range(99);
         if (r < 4) begin
            send_key_event(2'($urandom_range(3)), 7'($urandom_range(127)),
                           4'($urandom_range(15)));
         end else if (r < 4 + press_pct) begin
            send_key_event(MODE_PRESS, pick, 4'($urandom_range(15)));
         end else if (r < 90) begin
            if (held_entries > 0 && $urandom_range(99) < 80)
               pick = held_notes[$urandom_range(held_entries - 1)];
            send_key_event(MODE_RELEASE, pick, 4'($urandom_range(15)));
         end else begin
            send_key_event(($urandom_range(3) == 0) ? MODE_UNUSED : MODE_QUERY,
                           pick, 4'($urandom_range(15)));
         end
      end
      no_gaps = 1'b0;
   endtask

   task automatic test_count_saturation();
      logic [6:0] target;
      target = (held_entries > 0) ? held_notes[0] : 7'd99;
      for (int i = 0; i < 258; i++) send_key_event(MODE_PRESS, target, 4'($urandom_range(15)));
      send_key_event(MODE_RELEASE, target, 4'd0);
      send_key_event(MODE_QUERY,   target, 4'd0);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = MODE_QUERY;
      req_note       = 7'd0;
      req_slot_index = 4'd0;
      rsp_stall      = 1'b0;
      no_gaps        = 1'b0;
      held_entries   = 0;
      error_count    = 0;
      cycle_count    = 0;
      press_count    = 0;
      release_count  = 0;
      query_count    = 0;
      full_hits      = 0;
      saturated_hits = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_basic_events();
      test_full_stack();
      test_random_play(210);
      test_count_saturation();

      req_valid <= 1'b0;
      while (view_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d presses, %0d releases, %0d queries with random idling",
               press_count, release_count, query_count);
      $display("full-stack rejects %0d, saturated presses %0d, mismatches %0d",
               full_hits, saturated_hits, error_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
